>>> rtl/u8dec_pkg.sv
package u8dec_pkg;

    // Width of the byte and unit counters; they saturate at their largest value.
    localparam int COUNT_WIDTH = 16;
    localparam int LIMIT_WIDTH = 16;
    // Compare width: holds a counter plus two without wrapping, and any limit.
    localparam int CMP_WIDTH =
        ((COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH) + 2;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = '1;

    // Lead byte classes.
    localparam logic [7:0] LEAD3_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_MASK = 8'hC0;
    localparam logic [7:0] CONT_MARK  = 8'h80;
    localparam logic [7:0] LEAD3_KEEP = 8'h0F;
    localparam logic [7:0] LEAD2_KEEP = 8'h1F;
    localparam logic [7:0] CONT_KEEP  = 8'h3F;
    localparam logic [15:0] UNIT_BAD  = 16'hFFFF;

    // Register indexes on the configuration port.
    localparam logic REG_MAX_IN  = 1'b0;
    localparam logic REG_MAX_OUT = 1'b1;

    typedef enum logic [2:0] {
        KIND_UNIT      = 3'd0,
        KIND_END       = 3'd1,
        KIND_IN_LIMIT  = 3'd2,
        KIND_OUT_LIMIT = 3'd3,
        KIND_BAD       = 3'd4
    } t_kind;

    typedef struct packed {
        logic [1:0]             pending;
        logic [15:0]            acc;
        logic [COUNT_WIDTH-1:0] pos;
        logic [COUNT_WIDTH-1:0] units;
        logic                   discarding;
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] code_unit;
        logic [15:0] unit_count;
    } t_result;

endpackage

>>> rtl/u8dec_step.sv
module u8dec_step
    import u8dec_pkg::*;
(
    input  t_state                 i_state,
    input  logic [7:0]             i_byte,
    input  logic [LIMIT_WIDTH-1:0] i_max_in,
    input  logic [LIMIT_WIDTH-1:0] i_max_out,
    output t_state                 o_state,
    output logic                   o_emit,
    output t_result                o_result
);

    logic                   lead3;
    logic                   lead2;
    logic                   in_fail;
    logic                   out_fail;
    logic [CMP_WIDTH-1:0]   pos_ext;
    logic [CMP_WIDTH-1:0]   lim_in_ext;
    logic [CMP_WIDTH-1:0]   units_ext;
    logic [CMP_WIDTH-1:0]   lim_out_ext;
    logic [COUNT_WIDTH-1:0] pos_inc;
    logic [COUNT_WIDTH-1:0] units_inc;
    logic [1:0]             pend_dec;
    logic [15:0]            acc_new;

    // Lead byte classes and limit checks, made in a width that cannot wrap.
    assign lead3       = (i_byte & LEAD3_MASK) == LEAD3_MASK;
    assign lead2       = (i_byte & LEAD2_MASK) == LEAD2_MASK;
    assign pos_ext     = CMP_WIDTH'(i_state.pos);
    assign lim_in_ext  = CMP_WIDTH'(i_max_in);
    assign units_ext   = CMP_WIDTH'(i_state.units);
    assign lim_out_ext = CMP_WIDTH'(i_max_out);
    assign in_fail     = (pos_ext >= lim_in_ext)
                      || (lead2 && (pos_ext + CMP_WIDTH'(1) >= lim_in_ext))
                      || (lead3 && (pos_ext + CMP_WIDTH'(2) >= lim_in_ext));
    assign out_fail    = units_ext + CMP_WIDTH'(1) >= lim_out_ext;

    // Saturating counter steps.
    assign pos_inc   = (i_state.pos == COUNT_MAX) ? i_state.pos
                                                  : i_state.pos + COUNT_WIDTH'(1);
    assign units_inc = (i_state.units == COUNT_MAX) ? i_state.units
                                                    : i_state.units + COUNT_WIDTH'(1);

    // A continuation byte adds six bits at the place the remaining count gives.
    assign pend_dec = i_state.pending - 2'd1;
    assign acc_new  = (pend_dec == 2'd1)
                    ? (i_state.acc | {4'b0, (i_byte & CONT_KEEP) & 8'h3F, 4'b0} << 2)
                    : (i_state.acc | {8'b0, i_byte & CONT_KEEP});

    // One decode step: next string state and at most one result.
    always_comb begin
        o_state             = i_state;
        o_emit              = 1'b0;
        o_result.kind       = KIND_UNIT;
        o_result.code_unit  = '0;
        o_result.unit_count = 16'(i_state.units);
        if (i_state.discarding) begin
            if (i_byte == 8'd0) begin
                o_state = '0;
            end
        end else if (i_state.pending == 2'd0) begin
            if (i_byte == 8'd0) begin
                o_emit        = 1'b1;
                o_result.kind = KIND_END;
                o_state       = '0;
            end else if (in_fail) begin
                o_emit             = 1'b1;
                o_result.kind      = KIND_IN_LIMIT;
                o_state.discarding = 1'b1;
            end else if (out_fail) begin
                o_emit             = 1'b1;
                o_result.kind      = KIND_OUT_LIMIT;
                o_state.discarding = 1'b1;
            end else if (i_byte < CONT_MARK) begin
                o_emit              = 1'b1;
                o_state.pos         = pos_inc;
                o_state.units       = units_inc;
                o_result.code_unit  = {8'b0, i_byte};
                o_result.unit_count = 16'(units_inc);
            end else if (lead3) begin
                o_state.acc     = {(i_byte & LEAD3_KEEP) & 8'h0F, 8'b0} << 4;
                o_state.pending = 2'd2;
                o_state.pos     = pos_inc;
            end else if (lead2) begin
                o_state.acc     = {8'b0, i_byte & LEAD2_KEEP} << 6;
                o_state.pending = 2'd1;
                o_state.pos     = pos_inc;
            end else begin
                o_emit             = 1'b1;
                o_result.kind      = KIND_BAD;
                o_state.discarding = 1'b1;
            end
        end else begin
            if (i_byte == 8'd0) begin
                o_emit        = 1'b1;
                o_result.kind = KIND_BAD;
                o_state       = '0;
            end else begin
                o_state.pos     = pos_inc;
                o_state.pending = pend_dec;
                if (pend_dec != 2'd0) begin
                    o_state.acc = acc_new;
                end else if (acc_new == UNIT_BAD) begin
                    o_emit             = 1'b1;
                    o_result.kind      = KIND_BAD;
                    o_state.acc        = '0;
                    o_state.discarding = 1'b1;
                end else begin
                    o_emit              = 1'b1;
                    o_state.acc         = '0;
                    o_state.units       = units_inc;
                    o_result.code_unit  = acc_new;
                    o_result.unit_count = 16'(units_inc);
                end
            end
        end
    end

endmodule

>>> rtl/utf8_to_ucs2_stream_decoder.sv
// Channel   Direction  Signals                               Contents
// s         in         i_s_tvalid o_s_tready i_s_tdata        one UTF-8 byte per word
// m         out        o_m_tvalid i_m_tready o_m_tdata tuser  unit, count and result kind
// apb       in         i_psel i_penable i_pwrite i_paddr ...  byte and unit limits
//
// The decode step sits between the string state registers and the output
// register, so a word can be accepted every cycle while the skid register is empty.
// A result goes to the output register, or to the skid register while it is stalled.
// A two-word output stage (output register plus skid register) lets input
// continue after the output stalls until one more result has been produced;
// o_s_tready drops only while the skid register holds a result. Reset clears
// the string state, empties the output stage and sets both limits to their
// largest value.
module utf8_to_ucs2_stream_decoder
    import u8dec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    // Output stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [15:0] code_unit, [31:16] unit_count
    output logic [2:0]  o_m_tuser,   // [2:0] kind
    // Configuration port.
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    logic [LIMIT_WIDTH-1:0] r_max_in;
    logic [LIMIT_WIDTH-1:0] r_max_out;
    t_state                 r_state;
    t_state                 n_state;
    logic                   r_ov;
    logic                   n_ov;
    logic                   r_sv;
    logic                   n_sv;
    t_result                r_out;
    t_result                n_out;
    t_result                r_skid;
    t_result                n_skid;
    t_result                step_result;
    t_state                 step_state;
    logic                   step_emit;
    logic                   in_accept;
    logic                   out_take;
    logic                   cfg_write;

    // Configuration registers.
    assign o_pready  = 1'b1;
    assign cfg_write = i_psel && i_penable && i_pwrite && o_pready;
    assign o_prdata  = (i_paddr[2] == REG_MAX_OUT) ? 32'(r_max_out) : 32'(r_max_in);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_in  <= LIMIT_RESET;
            r_max_out <= LIMIT_RESET;
        end else if (cfg_write) begin
            if (i_paddr[2] == REG_MAX_IN) begin
                r_max_in <= i_pwdata[LIMIT_WIDTH-1:0];
            end else begin
                r_max_out <= i_pwdata[LIMIT_WIDTH-1:0];
            end
        end
    end

    // Decode step on the incoming word.
    u8dec_step u_step (
        .i_state   (r_state),
        .i_byte    (i_s_tdata),
        .i_max_in  (r_max_in),
        .i_max_out (r_max_out),
        .o_state   (step_state),
        .o_emit    (step_emit),
        .o_result  (step_result)
    );

    assign o_s_tready = !r_sv;
    assign in_accept  = i_s_tvalid && o_s_tready;
    assign out_take   = r_ov && i_m_tready;

    // String state and output stage.
    always_comb begin
        n_state = in_accept ? step_state : r_state;
        n_ov    = r_ov;
        n_sv    = r_sv;
        n_out   = r_out;
        n_skid  = r_skid;
        if (out_take) begin
            if (r_sv) begin
                n_out = r_skid;
                n_sv  = 1'b0;
            end else begin
                n_ov = 1'b0;
            end
        end
        if (in_accept && step_emit) begin
            if (!r_ov || out_take) begin
                n_out = step_result;
                n_ov  = 1'b1;
            end else begin
                n_skid = step_result;
                n_sv   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_ov    <= 1'b0;
            r_sv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_sv    <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {r_out.unit_count, r_out.code_unit};
    assign o_m_tuser  = r_out.kind;

endmodule

>>> rtl/u8dec_checker.sv
module u8dec_checker
    import u8dec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_s_tready,
    input  logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] o_m_tdata,
    input  logic [2:0]  o_m_tuser
);

    // A stalled result word holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("output word changed while stalled");

    // Input back-pressure only happens while a result is waiting.
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with empty output");

    // Anything other than a code unit carries a zero code unit.
    a_zero_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != KIND_UNIT) |-> o_m_tdata[15:0] == 16'd0)
        else $error("non-unit result with non-zero code unit");

    // The reserved value never leaves as a code unit.
    a_no_bad_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_UNIT) |-> o_m_tdata[15:0] != UNIT_BAD)
        else $error("code unit 0xFFFF emitted");

    // Input back-pressure ends on the cycle after a stalled output word is taken.
    a_ready_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready && i_m_tready |=> o_s_tready)
        else $error("input stayed stalled after output was taken");

endmodule

bind utf8_to_ucs2_stream_decoder u8dec_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
